/* design/hhps_pkg.sv */
// Package with the shared types, constants and palette function of the hue segmenter.
`timescale 1ns / 1ps
package hhps_pkg;

	localparam int HUE_BINS   = 360;
	localparam int HUE_SLOTS  = 180;
	localparam int PEAK_SLOTS = 180;
	localparam logic [7:0] HUE_LAST  = 8'd179;
	localparam logic [8:0] BIN_LAST  = 9'd359;
	localparam logic [7:0] EDGE_HUE  = 8'd178;

	typedef enum logic [1:0] {
		OP_COUNT    = 2'd0,
		OP_BUILD    = 2'd1,
		OP_CLASSIFY = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_PRIME0,
		ST_PRIME1,
		ST_PRIME2,
		ST_SWEEP,
		ST_DRAIN,
		ST_CL_RD,
		ST_CL_LOOP,
		ST_LD_BLD,
		ST_CLS_RD,
		ST_CLS_LD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       clear_hist;
		logic       hist_ren;
		logic       hist_sel_hue;
		logic [7:0] hist_addr;
		logic       cnt_wr;
		logic       prime1;
		logic       prime2;
		logic       shift;
		logic       hold_edge;
		logic       sweep;
		logic [8:0] bin;
		logic       pass_peaks;
		logic       start_max;
		logic       start_peaks;
		logic       cl_start;
		logic       cl_ren;
		logic       cl_adv;
		logic       cl_wr;
		logic [7:0] cl_k;
		logic       cls_ren;
		logic       ld_bld;
		logic       ld_cls;
	} cmd_t;

	typedef struct packed {
		logic no_peaks;
		logic cl_adv;
	} status_t;

	typedef struct packed {
		logic [7:0] color_c0;
		logic [7:0] color_c1;
		logic [7:0] color_c2;
		logic [7:0] cluster_index;
		logic       labeled;
		logic [7:0] peak_count;
	} result_t;

	function automatic logic [23:0] palette_color(input logic [7:0] c);
		logic [4:0] s;
		logic [3:0] t;
		logic [2:0] m;
		s = 5'(c[7:6]) + 5'(c[5:3]) + 5'(c[2:0]);
		t = 4'(s[4:3]) + 4'(s[2:0]);
		m = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
		case (m)
			3'd0: palette_color = {8'd255, 8'd0, 8'd0};
			3'd1: palette_color = {8'd0, 8'd255, 8'd0};
			3'd2: palette_color = {8'd0, 8'd0, 8'd255};
			3'd3: palette_color = {8'd255, 8'd255, 8'd0};
			3'd4: palette_color = {8'd255, 8'd0, 8'd255};
			3'd5: palette_color = {8'd0, 8'd255, 8'd255};
			3'd6: palette_color = {8'd128, 8'd128, 8'd128};
			default: palette_color = 24'd0;
		endcase
	endfunction

endpackage

/* design/hhps_pix_if.sv */
// Input channel interface carrying one pixel operation per transfer.
`timescale 1ns / 1ps
interface hhps_pix_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] pixel_hue;

	modport source (output valid, output op, output pixel_hue, input ready);
	modport sink (input valid, input op, input pixel_hue, output ready);
endinterface

/* design/hhps_res_if.sv */
// Output channel interface carrying one segmentation result per transfer.
`timescale 1ns / 1ps
interface hhps_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] color_c0;
	logic [7:0] color_c1;
	logic [7:0] color_c2;
	logic [7:0] cluster_index;
	logic       labeled;
	logic [7:0] peak_count;

	modport source (output valid, output color_c0, output color_c1, output color_c2,
		output cluster_index, output labeled, output peak_count, input ready);
	modport sink (input valid, input color_c0, input color_c1, input color_c2,
		input cluster_index, input labeled, input peak_count, output ready);
endinterface

/* design/hhps_dp.sv */
// Datapath with the histogram, smoothing window, peak and cluster memories and result register.
`timescale 1ns / 1ps
module hhps_dp #(
	parameter int COUNT_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hhps_pkg::cmd_t  cmd,
	input  logic [7:0]      pixel_hue,
	output hhps_pkg::status_t sts,
	output hhps_pkg::result_t res
);
	import hhps_pkg::*;

	localparam int SW = COUNT_BITS + 4;

	logic [COUNT_BITS-1:0] hist_mem [HUE_SLOTS];
	logic [HUE_SLOTS-1:0]  hist_vld_q;
	logic [COUNT_BITS-1:0] hist_rd_q;
	logic                  hist_rd_vld_q;
	logic [8:0]            left_mem [PEAK_SLOTS];
	logic [8:0]            left_rd_q;
	logic [7:0]            clu_mem [HUE_SLOTS];
	logic [7:0]            clu_rd_q;

	logic [7:0]            hue_q;
	logic                  hue_ok_q;
	logic [COUNT_BITS-1:0] w0_q, w1_q, w2_q;
	logic [SW-1:0]         s_now;
	logic [SW-1:0]         s_s1, s_s2, s_s3;
	logic                  v_s1;
	logic [8:0]            b_s1;
	logic [SW-1:0]         max_q;
	logic [7:0]            n_q;
	logic [8:0]            q_q;
	logic [7:0]            i_q;
	result_t               res_q;

	logic [COUNT_BITS-1:0] rdv;
	logic [7:0]            hist_ra;
	logic                  hue_in;
	logic                  hist_rd_en;
	logic [8:0]            c_bin;
	logic [SW+3:0]         s_x10;
	logic                  pk_wr;
	logic [9:0]            pk_sum;
	logic [8:0]            pk_left;
	logic [8:0]            i_next;
	logic                  have_next;
	logic [23:0]           pal;

	assign hue_in     = (hue_q <= HUE_LAST);
	assign hist_ra    = cmd.hist_sel_hue ? hue_q : cmd.hist_addr;
	assign hist_rd_en = cmd.hist_ren && (!cmd.hist_sel_hue || hue_in);
	assign rdv        = hist_rd_vld_q ? hist_rd_q : '0;

	always_comb begin
		if (cmd.bin[0]) begin
			s_now = (SW'(w1_q) + SW'(w2_q)) << 2;
		end else begin
			s_now = SW'(w0_q) + (SW'(w1_q) << 2) + (SW'(w1_q) << 1) + SW'(w2_q);
		end
	end

	assign c_bin   = b_s1 - 9'd1;
	assign s_x10   = ((SW+4)'(s_s2) << 3) + ((SW+4)'(s_s2) << 1);
	assign pk_wr   = v_s1 && cmd.pass_peaks && (b_s1 >= 9'd2) && (s_s2 > s_s3)
		&& (s_s2 > s_s1) && (s_x10 > (SW+4)'(max_q)) && (n_q < 8'(PEAK_SLOTS));
	assign pk_sum  = 10'(q_q) + 10'(c_bin);
	assign pk_left = (n_q == 8'd0) ? 9'd0 : pk_sum[9:1];

	assign i_next    = 9'(i_q) + 9'd1;
	assign have_next = (i_next < 9'(n_q));
	assign sts.cl_adv   = have_next && (left_rd_q <= {cmd.cl_k, 1'b0});
	assign sts.no_peaks = (n_q == 8'd0);

	assign pal = palette_color(clu_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr && hue_in && (rdv != '1)) begin
			hist_mem[hue_q] <= rdv + COUNT_BITS'(1);
		end
		if (hist_rd_en) begin
			hist_rd_q <= hist_mem[hist_ra];
		end
		if (pk_wr) begin
			left_mem[n_q] <= pk_left;
		end
		if (cmd.cl_ren && have_next) begin
			left_rd_q <= left_mem[i_next[7:0]];
		end
		if (cmd.cl_wr) begin
			clu_mem[cmd.cl_k] <= i_q;
		end
		if (cmd.cls_ren && hue_in) begin
			clu_rd_q <= clu_mem[hue_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hue_q <= pixel_hue;
		end
		if (cmd.cls_ren) begin
			hue_ok_q <= hue_in && (n_q != 8'd0);
		end
		if (cmd.prime1) begin
			w1_q <= rdv;
		end
		if (cmd.prime2) begin
			w0_q <= rdv;
			w2_q <= rdv;
		end
		if (cmd.shift) begin
			w0_q <= w1_q;
			w1_q <= w2_q;
			w2_q <= cmd.hold_edge ? w2_q : rdv;
		end
		if (cmd.sweep) begin
			s_s1 <= s_now;
			b_s1 <= cmd.bin;
		end
		if (v_s1) begin
			s_s2 <= s_s1;
			s_s3 <= s_s2;
		end
		if (cmd.ld_bld) begin
			res_q <= '{color_c0: 8'd0, color_c1: 8'd0, color_c2: 8'd0,
				cluster_index: 8'd0, labeled: 1'b0, peak_count: n_q};
		end
		if (cmd.ld_cls) begin
			res_q <= '{color_c0: hue_ok_q ? pal[23:16] : 8'd0,
				color_c1: hue_ok_q ? pal[15:8] : 8'd0,
				color_c2: hue_ok_q ? pal[7:0] : 8'd0,
				cluster_index: hue_ok_q ? clu_rd_q : 8'd0,
				labeled: hue_ok_q, peak_count: n_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_rd_vld_q <= 1'b0;
			v_s1          <= 1'b0;
			max_q         <= '0;
			n_q           <= 8'd0;
			q_q           <= 9'd0;
			i_q           <= 8'd0;
		end else begin
			if (cmd.clear_hist) begin
				hist_vld_q <= '0;
			end else if (cmd.cnt_wr && hue_in) begin
				hist_vld_q[hue_q] <= 1'b1;
			end
			if (hist_rd_en) begin
				hist_rd_vld_q <= hist_vld_q[hist_ra];
			end
			v_s1 <= cmd.sweep;
			if (cmd.start_max) begin
				max_q <= '0;
			end else if (v_s1 && !cmd.pass_peaks && (s_s1 > max_q)) begin
				max_q <= s_s1;
			end
			if (cmd.start_peaks) begin
				n_q <= 8'd0;
				q_q <= 9'd0;
			end else if (pk_wr) begin
				n_q <= n_q + 8'd1;
				q_q <= c_bin;
			end
			if (cmd.cl_start) begin
				i_q <= 8'd0;
			end else if (cmd.cl_adv) begin
				i_q <= i_q + 8'd1;
			end
		end
	end

	assign res = res_q;

endmodule

/* design/hhps_ctrl.sv */
// Controller state machine sequencing count, build sweeps, cluster fill and classify.
`timescale 1ns / 1ps
module hhps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  hhps_pkg::status_t   sts,
	output hhps_pkg::cmd_t      cmd
);
	import hhps_pkg::*;

	state_t     state_q, state_d;
	logic [8:0] b_q, b_d;
	logic [7:0] k_q, k_d;
	logic       pass_q, pass_d;
	logic [7:0] half;

	assign half = b_q[8:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			b_q     <= 9'd0;
			k_q     <= 8'd0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			b_q     <= b_d;
			k_q     <= k_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		b_d       = b_q;
		k_d       = k_q;
		pass_d    = pass_q;
		cmd       = '0;
		cmd.bin   = b_q;
		cmd.cl_k  = k_q;
		cmd.pass_peaks = pass_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					case (op_t'(in_op))
						OP_COUNT:    state_d = ST_CNT_RD;
						OP_CLASSIFY: state_d = ST_CLS_RD;
						OP_CLEAR:    cmd.clear_hist = 1'b1;
						OP_BUILD: begin
							state_d = ST_PRIME0;
							pass_d  = 1'b0;
							cmd.start_max = 1'b1;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CNT_RD: begin
				cmd.hist_ren     = 1'b1;
				cmd.hist_sel_hue = 1'b1;
				state_d          = ST_CNT_WR;
			end
			ST_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_PRIME0: begin
				cmd.hist_ren  = 1'b1;
				cmd.hist_addr = 8'd0;
				b_d           = 9'd0;
				state_d       = ST_PRIME1;
			end
			ST_PRIME1: begin
				cmd.hist_ren  = 1'b1;
				cmd.hist_addr = 8'd1;
				cmd.prime1    = 1'b1;
				state_d       = ST_PRIME2;
			end
			ST_PRIME2: begin
				cmd.prime2 = 1'b1;
				state_d    = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (!b_q[0]) begin
					cmd.hist_ren  = 1'b1;
					cmd.hist_addr = (half >= EDGE_HUE) ? HUE_LAST : half + 8'd2;
				end else begin
					cmd.shift     = 1'b1;
					cmd.hold_edge = (half >= EDGE_HUE);
				end
				if (b_q == BIN_LAST) begin
					state_d = ST_DRAIN;
				end else begin
					b_d = b_q + 9'd1;
				end
			end
			ST_DRAIN: begin
				if (!pass_q) begin
					pass_d          = 1'b1;
					cmd.start_peaks = 1'b1;
					state_d         = ST_PRIME0;
				end else begin
					cmd.cl_start = 1'b1;
					k_d          = 8'd0;
					state_d      = ST_CL_RD;
				end
			end
			ST_CL_RD: begin
				if (sts.no_peaks) begin
					state_d = ST_LD_BLD;
				end else begin
					cmd.cl_ren = 1'b1;
					state_d    = ST_CL_LOOP;
				end
			end
			ST_CL_LOOP: begin
				if (sts.cl_adv) begin
					cmd.cl_adv = 1'b1;
					state_d    = ST_CL_RD;
				end else begin
					cmd.cl_wr = 1'b1;
					if (k_q == HUE_LAST) begin
						state_d = ST_LD_BLD;
					end else begin
						k_d = k_q + 8'd1;
					end
				end
			end
			ST_LD_BLD: begin
				cmd.ld_bld = 1'b1;
				state_d    = ST_OUT;
			end
			ST_CLS_RD: begin
				cmd.cls_ren = 1'b1;
				state_d     = ST_CLS_LD;
			end
			ST_CLS_LD: begin
				cmd.ld_cls = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* design/hue_histogram_peak_segmenter.sv */
// Top level of the hue histogram peak segmenter: controller plus datapath.
// Count is a histogram read-modify-write in a read and a write state; clear ends in idle.
// Classify reads the cluster table, then loads the result register for the result transfer.
// Build runs a maximum sweep and a peak sweep of the smoothing window, then the cluster fill.
// One item is in work at a time; the next is taken back in idle, after any result transfer.
// Reset empties the histogram through per-bin valid flags and leaves no peaks known.
`timescale 1ns / 1ps
module hue_histogram_peak_segmenter #(
	parameter int COUNT_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	hhps_pix_if.sink   pixel,
	hhps_res_if.source result
);
	import hhps_pkg::*;

	cmd_t    cmd;
	status_t sts;
	result_t res;

	hhps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_op     (pixel.op),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hhps_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pixel_hue (pixel.pixel_hue),
		.sts       (sts),
		.res       (res)
	);

	assign result.color_c0      = res.color_c0;
	assign result.color_c1      = res.color_c1;
	assign result.color_c2      = res.color_c2;
	assign result.cluster_index = res.cluster_index;
	assign result.labeled       = res.labeled;
	assign result.peak_count    = res.peak_count;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the hue histogram peak segmenter with its own prediction of results.
`timescale 1ns / 1ps
module testbench;
	import hhps_pkg::*;

	localparam int CNT_W = 24;
	localparam int DRAIN_CYCLES = 2000;

	logic clk;
	logic arst_n;
	hhps_pix_if pix ();
	hhps_res_if res ();

	hue_histogram_peak_segmenter #(.COUNT_BITS(CNT_W)) dut (
		.clk(clk), .arst_n(arst_n), .pixel(pix.sink), .result(res.source)
	);

	logic [CNT_W-1:0] hist_bins[HUE_BINS];
	logic [CNT_W+3:0] smooth_bins[HUE_BINS];
	logic [8:0] peak_bins[PEAK_SLOTS];
	logic [7:0] peak_total;
	logic [7:0] bin_cluster[HUE_BINS];
	result_t expected_results[$];
	int mismatches;
	bit idle_enabled;
	int ready_gap = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [CNT_W-1:0] hist_reflect(input int i);
		if (i < 0)
			i = -i;
		if (i >= HUE_BINS)
			i = 2 * (HUE_BINS - 1) - i;
		return hist_bins[i];
	endfunction

	function automatic void rebuild_clusters();
		logic [CNT_W+3:0] s;
		logic [CNT_W+3:0] top;
		int n;
		int lo;
		int hi;
		top = '0;
		for (int i = 0; i < HUE_BINS; i++) begin
			s = (CNT_W+4)'((CNT_W+4)'(hist_reflect(i - 2))
				+ 4 * (CNT_W+4)'(hist_reflect(i - 1))
				+ 6 * (CNT_W+4)'(hist_reflect(i)) + 4 * (CNT_W+4)'(hist_reflect(i + 1))
				+ (CNT_W+4)'(hist_reflect(i + 2)));
			smooth_bins[i] = s;
			if (s > top)
				top = s;
		end
		n = 0;
		for (int i = 1; i < HUE_BINS - 1; i++) begin
			if (smooth_bins[i] > smooth_bins[i-1] && smooth_bins[i] > smooth_bins[i+1]
				&& 64'(smooth_bins[i]) * 10 > 64'(top) && n < PEAK_SLOTS) begin
				peak_bins[n] = 9'(i);
				n++;
			end
		end
		peak_total = 8'(n);
		for (int i = 0; i < n; i++) begin
			lo = (i > 0) ? (int'(peak_bins[i]) + int'(peak_bins[i-1])) / 2 : 0;
			hi = (i < n - 1) ? (int'(peak_bins[i]) + int'(peak_bins[i+1])) / 2 : HUE_BINS - 1;
			for (int j = lo; j <= hi; j++)
				bin_cluster[j] = 8'(i);
		end
	endfunction

	function automatic void predict_item(input op_t op, input logic [7:0] hue);
		result_t r;
		int c;
		r = '0;
		case (op)
			OP_CLEAR: begin
				foreach (hist_bins[i])
					hist_bins[i] = '0;
			end
			OP_COUNT: begin
				if (hue <= HUE_LAST && hist_bins[2 * hue] != {CNT_W{1'b1}})
					hist_bins[2 * hue] = hist_bins[2 * hue] + 1'b1;
			end
			OP_BUILD: begin
				rebuild_clusters();
				r.peak_count = peak_total;
				expected_results = {expected_results, r};
			end
			default: begin
				r.peak_count = peak_total;
				if (hue <= HUE_LAST && peak_total != 0) begin
					c = bin_cluster[2 * hue];
					{r.color_c0, r.color_c1, r.color_c2} =
						(c % 7 == 0) ? {8'd255, 8'd0, 8'd0} :
						(c % 7 == 1) ? {8'd0, 8'd255, 8'd0} :
						(c % 7 == 2) ? {8'd0, 8'd0, 8'd255} :
						(c % 7 == 3) ? {8'd255, 8'd255, 8'd0} :
						(c % 7 == 4) ? {8'd255, 8'd0, 8'd255} :
						(c % 7 == 5) ? {8'd0, 8'd255, 8'd255} : {8'd128, 8'd128, 8'd128};
					r.cluster_index = 8'(c);
					r.labeled = 1'b1;
				end
				expected_results = {expected_results, r};
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (res.color_c0 !== want.color_c0)
					report_mismatch("color_c0", res.color_c0, want.color_c0);
				if (res.color_c1 !== want.color_c1)
					report_mismatch("color_c1", res.color_c1, want.color_c1);
				if (res.color_c2 !== want.color_c2)
					report_mismatch("color_c2", res.color_c2, want.color_c2);
				if (res.cluster_index !== want.cluster_index)
					report_mismatch("cluster_index", res.cluster_index, want.cluster_index);
				if (res.labeled !== want.labeled)
					report_mismatch("labeled", res.labeled, want.labeled);
				if (res.peak_count !== want.peak_count)
					report_mismatch("peak_count", res.peak_count, want.peak_count);
			end
		end
	end

	always @(posedge clk) begin
		if (ready_gap != 0) begin
			ready_gap <= ready_gap - 1;
			res.ready <= (ready_gap == 1);
		end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
			ready_gap <= $urandom_range(1, 7);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic send_item(input op_t op, input logic [7:0] hue);
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.op <= op;
		pix.pixel_hue <= hue;
		do
			@(posedge clk);
		while (!pix.ready);
		predict_item(op, hue);
	endtask

	task automatic settle_idle();
		pix.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] random_hue();
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom_range(180, 255));
		return 8'($urandom_range(0, 179));
	endfunction

	task automatic test_directed_edges();
		send_item(OP_CLASSIFY, 8'd10);
		send_item(OP_BUILD, 8'd0);
		send_item(OP_COUNT, 8'd0);
		send_item(OP_COUNT, HUE_LAST);
		send_item(OP_COUNT, 8'd255);
		send_item(OP_COUNT, 8'd180);
		send_item(OP_BUILD, 8'd0);
		send_item(OP_CLASSIFY, 8'd0);
		send_item(OP_CLASSIFY, HUE_LAST);
		send_item(OP_CLASSIFY, 8'd255);
		for (int i = 0; i < 4; i++)
			send_item(OP_COUNT, 8'd90);
		send_item(OP_COUNT, EDGE_HUE);
		send_item(OP_BUILD, 8'd0);
		send_item(OP_CLASSIFY, 8'd90);
		send_item(OP_CLEAR, 8'd0);
		send_item(OP_CLASSIFY, 8'd90);
		send_item(OP_BUILD, 8'd0);
		send_item(OP_CLASSIFY, 8'd90);
	endtask

	task automatic test_many_peaks();
		for (int h = 1; h < HUE_SLOTS; h += 3)
			send_item(OP_COUNT, 8'(h));
		send_item(OP_BUILD, 8'd0);
		for (int i = 0; i < 30; i++)
			send_item(OP_CLASSIFY, random_hue());
		send_item(OP_CLEAR, 8'd0);
	endtask

	task automatic test_random_frames(input int frames);
		int centers;
		int base[4];
		for (int f = 0; f < frames; f++) begin
			if ($urandom_range(0, 3) != 0)
				send_item(OP_CLEAR, 8'd0);
			centers = $urandom_range(1, 4);
			foreach (base[i])
				base[i] = $urandom_range(0, 179);
			repeat ($urandom_range(10, 60)) begin
				if ($urandom_range(0, 9) == 0)
					send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				else
					send_item(OP_COUNT, 8'((base[$urandom_range(0, centers - 1)]
						+ $urandom_range(0, 6)) % 180));
			end
			send_item(OP_BUILD, 8'($urandom_range(0, 255)));
			repeat ($urandom_range(5, 25))
				send_item(OP_CLASSIFY, random_hue());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.op = OP_COUNT;
		pix.pixel_hue = '0;
		res.ready = 1'b0;
		idle_enabled = 1'b1;
		mismatches = 0;
		foreach (hist_bins[i]) begin
			hist_bins[i] = '0;
			bin_cluster[i] = '0;
		end
		peak_total = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_edges();
		test_many_peaks();
		test_random_frames(28);
		idle_enabled = 1'b0;
		test_random_frames(7);
		settle_idle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
